>>> rtl/mhe_pkg.sv
`timescale 1ns / 1ps

package mhe_pkg;

	localparam int KEY_W = 32;
	localparam int STATUS_W = 2;

	// operation codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// key returned when extracting from an empty heap
	localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'sh7fff_ffff;

	// one finished result, handed from the sequencer to the output register
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

>>> rtl/mhe_req_if.sv
`timescale 1ns / 1ps

// request channel: one operation per transaction
interface mhe_req_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [mhe_pkg::KEY_W-1:0] key_in;

	modport source (output valid, output func, output key_in, input ready);
	modport sink (input valid, input func, input key_in, output ready);
endinterface

>>> rtl/mhe_rsp_if.sv
`timescale 1ns / 1ps

// response channel: one result per transaction
interface mhe_rsp_if;
	logic valid;
	logic ready;
	logic signed [mhe_pkg::KEY_W-1:0] key_out;
	logic [mhe_pkg::STATUS_W-1:0] status;

	modport source (output valid, output key_out, output status, input ready);
	modport sink (input valid, input key_out, input status, output ready);
endinterface

>>> rtl/min_heap_extract.sv
`timescale 1ns / 1ps
// Load and failed extract go from accept through ST_DONE to the output register;
// extract goes through ST_ROOT, then one ST_SIFT step for each sift-down level visited.
// One transaction at a time; each sift level reads both children from the two
// read ports of the heap memory and writes one entry back.
// Reset clears the entry count and control; heap memory contents are kept.
module min_heap_extract #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	mhe_req_if.sink req,
	mhe_rsp_if.source rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic res_valid;
	logic res_ready;
	mhe_pkg::res_t res;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic signed [mhe_pkg::KEY_W-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr0;
	logic [IW-1:0] mem_raddr1;
	logic signed [mhe_pkg::KEY_W-1:0] mem_rdata0;
	logic signed [mhe_pkg::KEY_W-1:0] mem_rdata1;

	logic out_valid_q;
	mhe_pkg::res_t out_q;

	mhe_ctrl #(
		.CAPACITY(CAPACITY),
		.IW(IW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_func(req.func),
		.req_key(req.key_in),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr0(mem_raddr0),
		.mem_raddr1(mem_raddr1),
		.mem_rdata0(mem_rdata0),
		.mem_rdata1(mem_rdata1)
	);

	mhe_ram #(
		.DEPTH(CAPACITY),
		.AW(IW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr0(mem_raddr0),
		.raddr1(mem_raddr1),
		.rdata0(mem_rdata0),
		.rdata1(mem_rdata1)
	);

	// output register: frees the sequencer while a result waits
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.key_out = out_q.key;
	assign rsp.status = out_q.status;

endmodule

>>> rtl/mhe_ram.sv
`timescale 1ns / 1ps

// heap array: one write port, two read ports, registered read data
module mhe_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic signed [mhe_pkg::KEY_W-1:0] wdata,
	input logic [AW-1:0] raddr0,
	input logic [AW-1:0] raddr1,
	output logic signed [mhe_pkg::KEY_W-1:0] rdata0,
	output logic signed [mhe_pkg::KEY_W-1:0] rdata1
);

	logic signed [mhe_pkg::KEY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

>>> rtl/mhe_ctrl.sv
`timescale 1ns / 1ps

// sequencer: load append, root extract and one sift-down level per cycle
module mhe_ctrl #(
	parameter int CAPACITY = 64,
	parameter int IW = 6,
	parameter int CW = 7
) (
	input logic clk,
	input logic arst_n,
	// request side
	input logic req_valid,
	output logic req_ready,
	input logic req_func,
	input logic signed [mhe_pkg::KEY_W-1:0] req_key,
	// result side
	output logic res_valid,
	input logic res_ready,
	output mhe_pkg::res_t res,
	// memory side
	output logic mem_we,
	output logic [IW-1:0] mem_waddr,
	output logic signed [mhe_pkg::KEY_W-1:0] mem_wdata,
	output logic [IW-1:0] mem_raddr0,
	output logic [IW-1:0] mem_raddr1,
	input logic signed [mhe_pkg::KEY_W-1:0] mem_rdata0,
	input logic signed [mhe_pkg::KEY_W-1:0] mem_rdata1
);

	// child indexes need one bit more than the count
	localparam int AW = CW + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SIFT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] pos_q;
	logic signed [mhe_pkg::KEY_W-1:0] cur_q;
	mhe_pkg::res_t res_q;

	logic accept;
	logic is_full;
	logic [AW-1:0] lc;
	logic [AW-1:0] rc;
	logic lc_ok;
	logic rc_ok;
	logic [AW-1:0] best;
	logic signed [mhe_pkg::KEY_W-1:0] best_key;
	logic swap;
	logic [IW-1:0] best_pos;
	logic [AW-1:0] nlc;
	logic [AW-1:0] nrc;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign is_full = (count_q >= CAP_C);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

	// children of the current position and which of them are live
	assign lc = (AW'(pos_q) << 1) + AW'(1);
	assign rc = lc + AW'(1);
	assign lc_ok = lc < AW'(count_q);
	assign rc_ok = rc < AW'(count_q);

	// smaller child, left on a tie, if it beats the key being sifted
	always_comb begin
		best = AW'(pos_q);
		best_key = cur_q;
		if (lc_ok && (mem_rdata0 < best_key)) begin
			best = lc;
			best_key = mem_rdata0;
		end
		if (rc_ok && (mem_rdata1 < best_key)) begin
			best = rc;
			best_key = mem_rdata1;
		end
	end

	assign swap = (best != AW'(pos_q));
	assign best_pos = best[IW-1:0];
	assign nlc = (AW'(best_pos) << 1) + AW'(1);
	assign nrc = nlc + AW'(1);

	// memory addressing
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = count_q[IW-1:0];
		mem_wdata = req_key;
		mem_raddr0 = '0;
		mem_raddr1 = IW'(count_q - CW'(1));
		unique case (state_q)
			ST_IDLE: begin
				mem_we = accept && (req_func == mhe_pkg::FUNC_LOAD) && !is_full;
			end
			ST_ROOT: begin
				mem_raddr0 = lc[IW-1:0];
				mem_raddr1 = rc[IW-1:0];
			end
			ST_SIFT: begin
				// move the smaller child up, or park the sifted key
				mem_we = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = swap ? best_key : cur_q;
				mem_raddr0 = nlc[IW-1:0];
				mem_raddr1 = nrc[IW-1:0];
			end
			ST_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			cur_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q <= '0;
						if (req_func == mhe_pkg::FUNC_LOAD) begin
							res_q.key <= '0;
							state_q <= ST_DONE;
							if (is_full) begin
								res_q.status <= mhe_pkg::STATUS_FULL;
							end else begin
								res_q.status <= mhe_pkg::STATUS_OK;
								count_q <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							res_q.key <= mhe_pkg::EMPTY_KEY;
							res_q.status <= mhe_pkg::STATUS_EMPTY;
							state_q <= ST_DONE;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					// root is the result, last entry starts the sift at the root
					res_q.key <= mem_rdata0;
					res_q.status <= mhe_pkg::STATUS_OK;
					cur_q <= mem_rdata1;
					state_q <= ST_SIFT;
				end
				ST_SIFT: begin
					if (swap) begin
						pos_q <= best_pos;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
